// ----- hdl/ecpb_pkg.sv -----
// Shared types and constants for the exact color palette builder.
// No dependencies; imported by every module of the block.
`default_nettype none

package ecpb_pkg;

    localparam int COLOR_W    = 24;
    localparam int CHAN_W     = 8;
    localparam int THR_W      = 9;
    localparam int CFG_DATA_W = 9;
    localparam int INDEX_W    = 8;

    localparam int CAP_SMALL = 16;
    localparam int CAP_LARGE = 256;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 9'd128;
    localparam logic             MODE_RESET      = 1'b1;

    localparam logic CFG_ALPHA_THRESHOLD = 1'b0;
    localparam logic CFG_PALETTE_MODE    = 1'b1;

    typedef struct packed {
        logic [COLOR_W-1:0] rgb;
        logic               image_start;
        logic               alpha_mask;
    } pix_item_t;

endpackage

`default_nettype wire

// ----- hdl/exact_color_palette_builder_core.sv -----
// Top level of the exact color palette builder: config registers, input stage,
// queue and search engine. Depends on ecpb_pkg, ecpb_front, ecpb_queue, ecpb_back.
//
// One pixel beat in gives one result beat out, in order. Each pixel is compared
// against the palette memory one entry per cycle over the entries filled so far;
// a match ends the scan early. A two-entry queue and the input register let new
// pixels arrive while a search runs.
`default_nettype none

module exact_color_palette_builder_core
    import ecpb_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [CHAN_W-1:0]     red,
    input  wire logic [CHAN_W-1:0]     green,
    input  wire logic [CHAN_W-1:0]     blue,
    input  wire logic [CHAN_W-1:0]     alpha,
    input  wire logic                  image_start,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [INDEX_W-1:0]         palette_index,
    output logic                       new_entry,
    output logic                       no_free_colors,
    output logic                       alpha_mask
);

    logic [THR_W-1:0] threshold_reg;
    logic             mode_reg;
    logic             push;
    pix_item_t        push_item;
    logic             q_full;
    logic             pop;
    pix_item_t        pop_item;
    logic             q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            mode_reg      <= MODE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ALPHA_THRESHOLD: threshold_reg <= cfg_data[THR_W-1:0];
                CFG_PALETTE_MODE:    mode_reg      <= cfg_data[0];
                default:             mode_reg      <= mode_reg;
            endcase
        end
    end

    ecpb_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .red             (red),
        .green           (green),
        .blue            (blue),
        .alpha           (alpha),
        .image_start     (image_start),
        .alpha_threshold (threshold_reg),
        .push            (push),
        .push_item       (push_item),
        .q_full          (q_full)
    );

    ecpb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_empty   (q_empty)
    );

    ecpb_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .palette_mode   (mode_reg),
        .pop_item       (pop_item),
        .q_empty        (q_empty),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .palette_index  (palette_index),
        .new_entry      (new_entry),
        .no_free_colors (no_free_colors),
        .alpha_mask     (alpha_mask)
    );

endmodule

`default_nettype wire

// ----- hdl/ecpb_front.sv -----
// Input stage: registers one pixel beat, packs RGB and computes the alpha mask.
// Depends on ecpb_pkg; feeds ecpb_queue.
`default_nettype none

module ecpb_front
    import ecpb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [CHAN_W-1:0] red,
    input  wire logic [CHAN_W-1:0] green,
    input  wire logic [CHAN_W-1:0] blue,
    input  wire logic [CHAN_W-1:0] alpha,
    input  wire logic              image_start,
    input  wire logic [THR_W-1:0]  alpha_threshold,
    output logic                   push,
    output pix_item_t              push_item,
    input  wire logic              q_full
);

    logic      valid_reg;
    logic      valid_next;
    pix_item_t item_reg;
    logic      accept;

    assign push      = valid_reg & ~q_full;
    assign in_stall  = valid_reg & q_full;
    assign accept    = in_valid & ~in_stall;
    assign push_item = item_reg;
    assign valid_next = accept | (valid_reg & ~push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.rgb         <= {red, green, blue};
            item_reg.image_start <= image_start;
            item_reg.alpha_mask  <= ({1'b0, alpha} < alpha_threshold);
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ecpb_queue.sv -----
// Two-entry queue of classified pixels between the front and the search engine.
// Depends on ecpb_pkg.
`default_nettype none

module ecpb_queue
    import ecpb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  pix_item_t      push_item,
    output logic           q_full,
    input  wire logic      pop,
    output pix_item_t      pop_item,
    output logic           q_empty
);

    pix_item_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    assign q_full   = (fill_reg == 2'd2);
    assign q_empty  = (fill_reg == 2'd0);
    assign pop_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ecpb_back.sv -----
// Search engine: scans the palette memory one entry per cycle, appends misses,
// tracks the overflow flag and holds the result beat. Depends on ecpb_pkg.
`default_nettype none

module ecpb_back
    import ecpb_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               palette_mode,
    input  pix_item_t               pop_item,
    input  wire logic               q_empty,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [INDEX_W-1:0]      palette_index,
    output logic                    new_entry,
    output logic                    no_free_colors,
    output logic                    alpha_mask
);

    localparam int IW    = $clog2(PALETTE_DEPTH);
    localparam int CW    = $clog2(PALETTE_DEPTH + 1);
    localparam int CAP_S = (CAP_SMALL > PALETTE_DEPTH) ? PALETTE_DEPTH : CAP_SMALL;
    localparam int CAP_L = (CAP_LARGE > PALETTE_DEPTH) ? PALETTE_DEPTH : CAP_LARGE;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [COLOR_W-1:0] mem [PALETTE_DEPTH];
    logic [COLOR_W-1:0] rd_q;
    logic [IW-1:0]      rd_addr;
    logic               mem_we;
    logic [IW-1:0]      wr_addr;

    logic [1:0]         state_reg;
    logic [CW-1:0]      k_reg;
    logic               cmp_vld_reg;
    logic [IW-1:0]      cmp_idx_reg;
    logic [COLOR_W-1:0] cur_rgb_reg;
    logic               cur_mask_reg;
    logic [CW-1:0]      count_reg;
    logic               ovf_reg;
    logic [IW-1:0]      res_idx_reg;
    logic               res_new_reg;

    logic               out_valid_reg;
    logic [IW-1:0]      out_idx_reg;
    logic               out_new_reg;
    logic               out_ovf_reg;
    logic               out_mask_reg;

    logic [CW-1:0]      cap_cur;
    logic               hit;
    logic               issue;
    logic               out_free;

    assign cap_cur  = palette_mode ? CW'(CAP_L) : CW'(CAP_S);
    assign hit      = cmp_vld_reg && (rd_q == cur_rgb_reg);
    assign issue    = (k_reg < count_reg);
    assign out_free = ~out_valid_reg | ~out_stall;
    assign pop      = (state_reg == ST_IDLE) && !q_empty;
    assign rd_addr  = k_reg[IW-1:0];
    assign wr_addr  = count_reg[IW-1:0];
    assign mem_we   = (state_reg == ST_SCAN) && !hit && !issue && !cmp_vld_reg
                      && (count_reg < cap_cur);

    assign out_valid      = out_valid_reg;
    assign palette_index  = INDEX_W'(out_idx_reg);
    assign new_entry      = out_new_reg;
    assign no_free_colors = out_ovf_reg;
    assign alpha_mask     = out_mask_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= cur_rgb_reg;
        end
        rd_q <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            cmp_vld_reg   <= 1'b0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        if (pop_item.image_start)
                        begin
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                        end
                        k_reg       <= '0;
                        cmp_vld_reg <= 1'b0;
                        state_reg   <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (hit)
                    begin
                        cmp_vld_reg <= 1'b0;
                        state_reg   <= ST_DONE;
                    end
                    else if (issue)
                    begin
                        cmp_vld_reg <= 1'b1;
                        k_reg       <= k_reg + CW'(1);
                    end
                    else if (cmp_vld_reg)
                    begin
                        cmp_vld_reg <= 1'b0;
                    end
                    else
                    begin
                        if (count_reg < cap_cur)
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_rgb_reg  <= pop_item.rgb;
            cur_mask_reg <= pop_item.alpha_mask;
        end
        if (state_reg == ST_SCAN)
        begin
            if (issue && !hit)
            begin
                cmp_idx_reg <= k_reg[IW-1:0];
            end
            if (hit)
            begin
                res_idx_reg <= cmp_idx_reg;
                res_new_reg <= 1'b0;
            end
            else if (!issue && !cmp_vld_reg)
            begin
                res_idx_reg <= mem_we ? count_reg[IW-1:0] : '0;
                res_new_reg <= mem_we;
            end
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_idx_reg  <= res_idx_reg;
            out_new_reg  <= res_new_reg;
            out_ovf_reg  <= ovf_reg;
            out_mask_reg <= cur_mask_reg;
        end
    end

endmodule

`default_nettype wire
